@@ design/aks_pkg.sv @@
// Shared types, constants and AES tables for the key schedule scanner.
`timescale 1ns / 1ps
`default_nettype none
package aks_pkg;

  localparam int unsigned NumWords = 60;
  localparam int unsigned WinBytes = 4 * NumWords;
  localparam int unsigned OffsetW  = 32;
  localparam int unsigned StepW    = $clog2(NumWords);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic               found;
  } out_word_t;

  // checker to top level
  typedef struct packed {
    logic busy;
    logic rotate;
    logic done;
    logic found;
  } chk_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [16] = '{
    8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
    8'h80,8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a
  };

  function automatic logic [31:0] sbox_subst(input logic [31:0] w);
    sbox_subst = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

@@ design/aks_cell.sv @@
// One word cell of the scan window: byte shift on input, word rotate while checking.
`timescale 1ns / 1ps
`default_nettype none
module aks_cell (
  input  wire logic        clk_i,
  input  wire logic        shift_i,
  input  wire logic        rotate_i,
  input  wire logic [7:0]  next_byte_i,
  input  wire logic [31:0] next_word_i,
  output logic [31:0]      word_o
);
  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= {word_q[23:0], next_byte_i};
    end else if (rotate_i) begin
      word_q <= next_word_i;
    end
  end

  assign word_o = word_q;
endmodule
`default_nettype wire

@@ design/aks_check.sv @@
// Sequencer that walks the rotating window and checks the key expansion word by word.
`timescale 1ns / 1ps
`default_nettype none
module aks_check (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [3:0]        nk_i,
  input  wire logic [31:0]       head_i,
  input  wire logic              out_free_i,
  output aks_pkg::chk_status_t   status_o
);
  import aks_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;
  localparam logic [StepW-1:0] StepLast = StepW'(NumWords - 1);

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [2:0]       phase_q;
  logic [3:0]       rc_q;
  logic             ok_q;
  logic [31:0]      hist_q [8];

  logic [StepW-1:0] total_w, skip_w;
  logic [2:0]       nk_m1;
  logic             live, wrap, mism;
  logic [31:0]      t_w, exp_w;

  assign total_w = StepW'({nk_i + 4'd7, 2'b00});
  assign skip_w  = StepW'(NumWords) - total_w;
  assign nk_m1   = 3'(nk_i - 4'd1);
  assign live    = (state_q == StRun) && (step_q >= skip_w);
  assign wrap    = (phase_q == nk_m1);

  always_comb begin
    t_w = hist_q[0];
    if (phase_q == 3'd0) begin
      t_w = sbox_subst({hist_q[0][23:0], hist_q[0][31:24]}) ^ {RCON[rc_q], 24'h0};
    end else if (phase_q == 3'd4 && nk_i > 4'd6) begin
      t_w = sbox_subst(hist_q[0]);
    end
    exp_w = hist_q[nk_m1] ^ t_w;
    mism  = live && (rc_q != 4'd0) && (exp_w != head_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StRun;
      StRun:   if (step_q == StepLast) state_d = StHold;
      StHold:  if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      phase_q <= '0;
      rc_q    <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == StIdle) begin
        step_q  <= '0;
        phase_q <= '0;
        rc_q    <= '0;
        ok_q    <= 1'b1;
      end else if (state_q == StRun) begin
        step_q <= step_q + 1'b1;
        if (mism) ok_q <= 1'b0;
        if (live) begin
          if (wrap) begin
            phase_q <= '0;
            rc_q    <= rc_q + 4'd1;
          end else begin
            phase_q <= phase_q + 3'd1;
          end
        end
      end
    end
  end

  // history of the last eight candidate words, newest at index 0
  always_ff @(posedge clk_i) begin
    if (live) begin
      hist_q[0] <= head_i;
      for (int k = 1; k < 8; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  assign status_o.busy   = (state_q != StIdle);
  assign status_o.rotate = (state_q == StRun);
  assign status_o.done   = (state_q == StHold) && out_free_i;
  assign status_o.found  = ok_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == StIdle) else $error("check started while busy");
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && step_q == StepLast) |=> state_q == StHold)
    else $error("walk did not end after last word");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.done |=> state_q == StIdle) else $error("result issued twice");
endmodule
`default_nettype wire

@@ design/aes_key_schedule_scanner_top.sv @@
// Top level of the AES key schedule scanner: window cells, counters and output register.
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake              | Word
// ----------+-----------+------------------------+---------------------------
// in        | input     | in_valid_i / in_stall_o   | in_word_t: data_byte, restart
// out       | output    | out_valid_o / out_stall_i | out_word_t: offset, found
// cfg       | input     | cfg_valid_i / cfg_ready_o | key_words (4 bits)
//
// A byte that leaves the window short of 16*(Nk+7) bytes gives no word. A byte
// that completes a candidate is first shifted in; then the 60 word cells rotate
// past the checker (one word per cycle), and then the result is handed to the
// output register.
// The output register is single entry; a stalled output holds the checker in its
// final state while the next bytes wait. Reset clears counters and control; the
// window contents are not reset and are only read once refilled.
module aes_key_schedule_scanner_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire aks_pkg::in_word_t in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output aks_pkg::out_word_t     out_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [3:0]        cfg_data_i
);
  import aks_pkg::*;

  localparam logic [7:0] FillMax = 8'(WinBytes);

  logic [3:0]         key_q;
  logic [3:0]         nk;
  logic [7:0]         len_w;
  logic [7:0]         fill_q, fill_base, fill_d;
  logic [OffsetW-1:0] cnt_q, cnt_d, off_q;
  logic               accept, start;
  logic               out_valid_q, out_free;
  out_word_t          out_q;
  chk_status_t        chk;
  logic [31:0]        win [NumWords];

  assign cfg_ready_o = 1'b1;

  // out-of-range key lengths clamp to 4 or 8
  assign nk    = (key_q < 4'd4) ? 4'd4 : ((key_q > 4'd8) ? 4'd8 : key_q);
  assign len_w = 8'({nk + 4'd7, 4'b0000});

  assign in_stall_o = chk.busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fill_base = in_i.restart ? 8'd0 : fill_q;
    fill_d    = (fill_base == FillMax) ? FillMax : fill_base + 8'd1;
    cnt_d     = (in_i.restart ? '0 : cnt_q) + 1'b1;
    start     = accept && (fill_d >= len_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= 4'd4;
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_valid_i) key_q <= cfg_data_i;
      if (accept) begin
        fill_q <= fill_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // candidate start offset, kept while the check runs
  always_ff @(posedge clk_i) begin
    if (start) off_q <= cnt_d - OffsetW'(len_w);
  end

  // row of word cells; oldest byte sits in the top byte of cell 0
  for (genvar m = 0; m < NumWords; m++) begin : g_cell
    if (m == NumWords - 1) begin : g_last
      aks_cell u_cell (
        .clk_i      (clk_i),
        .shift_i    (accept),
        .rotate_i   (chk.rotate),
        .next_byte_i(in_i.data_byte),
        .next_word_i(win[0]),
        .word_o     (win[m])
      );
    end else begin : g_mid
      aks_cell u_cell (
        .clk_i      (clk_i),
        .shift_i    (accept),
        .rotate_i   (chk.rotate),
        .next_byte_i(win[m+1][31:24]),
        .next_word_i(win[m+1]),
        .word_o     (win[m])
      );
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  aks_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .nk_i      (nk),
    .head_i    (win[0]),
    .out_free_i(out_free),
    .status_o  (chk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chk.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk.done) begin
      out_q.offset <= off_q;
      out_q.found  <= chk.found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the AES key schedule scanner: directed, random and stall tests.
`timescale 1ns / 1ps
module tb_top;
  import aks_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Stimulus side
  logic       in_valid = 1'b0;
  in_word_t   in_word = '0;
  logic       in_stall;
  // Result side
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  // Key length register
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  always #5 clk = ~clk;

  aes_key_schedule_scanner_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Mirror of the scanner state
  logic [7:0]  scan_win [WinBytes];
  int unsigned scan_fill = 0;
  logic [31:0] scan_count = '0;
  logic [3:0]  key_len_reg = 4'd4;

  out_word_t   pending_q [$];
  int          n_errors = 0;
  int          n_bytes = 0;
  int          n_results = 0;
  int          n_found = 0;

  bit tx_idle = 1'b1;   // sender draws gaps when set
  bit rx_idle = 1'b1;   // receiver draws stalls when set
  bit rx_hold = 1'b0;   // request for a long receiver hold

  function automatic int eff_nk(input logic [3:0] k);
    if (k < 4) return 4;
    if (k > 8) return 8;
    return int'(k);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Full key expansion of the first nk words in sched
  function automatic void expand_key(input int nk, inout logic [31:0] sched [NumWords]);
    logic [31:0] t;
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[(i / nk) % 16], 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  // Does the newest 16*(nk+7) bytes of the window hold a valid expansion?
  function automatic bit window_has_schedule(input int nk);
    logic [31:0] sched [NumWords];
    int base;
    base = WinBytes - 16 * (nk + 7);
    for (int i = 0; i < 4 * (nk + 7); i++) begin
      sched[i] = {scan_win[base+4*i], scan_win[base+4*i+1],
                  scan_win[base+4*i+2], scan_win[base+4*i+3]};
    end
    begin
      logic [31:0] golden [NumWords];
      golden = sched;
      expand_key(nk, golden);
      for (int i = nk; i < 4 * (nk + 7); i++) begin
        if (golden[i] != sched[i]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the mirror by one accepted byte, queue the result it causes
  task automatic scan_byte(input in_word_t w);
    int nk;
    int len;
    out_word_t r;
    if (w.restart) begin
      scan_fill = 0;
      scan_count = '0;
    end
    for (int i = 0; i < WinBytes - 1; i++) scan_win[i] = scan_win[i+1];
    scan_win[WinBytes-1] = w.data_byte;
    if (scan_fill < WinBytes) scan_fill++;
    scan_count = scan_count + 32'd1;
    nk = eff_nk(key_len_reg);
    len = 16 * (nk + 7);
    if (scan_fill >= len) begin
      r.offset = scan_count - 32'(len);
      r.found = window_has_schedule(nk);
      pending_q.push_back(r);
    end
  endtask

  task automatic report(input string what);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Send one word on the input channel
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    in_word_t w;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    w.data_byte = b;
    w.restart = rs;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    scan_byte(w);
    n_bytes++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // a non-completing byte may still be in flight; give it the full check time
    repeat (70) @(posedge clk);
  endtask

  task automatic write_key_len(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_len_reg = v;
  endtask

  // One expansion of a random key; corrupt flips one random bit
  task automatic send_schedule(input int nk, input bit first_restart, input bit corrupt);
    logic [31:0] sched [NumWords];
    logic [7:0] b;
    int len;
    int bad;
    len = 16 * (nk + 7);
    for (int i = 0; i < nk; i++) sched[i] = $urandom;
    expand_key(nk, sched);
    bad = $urandom_range(0, len - 1);
    for (int j = 0; j < len; j++) begin
      b = sched[j/4][31 - 8*(j%4) -: 8];
      if (corrupt && j == bad) b ^= 8'(1 << $urandom_range(0, 7));
      send_byte(b, first_restart && j == 0);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 39) == 0);
  endtask

  // Extremes of the byte, restart, every key length including clamped codes
  task automatic test_directed();
    logic [3:0] codes [6] = '{4'd0, 4'd5, 4'd6, 4'd7, 4'd8, 4'd15};
    // bytes before a restart must not count toward the window fill
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_schedule(4, 1'b1, 1'b0);       // reset value of the key length
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    // key length changed mid-dump; longer windows give no word until filled
    foreach (codes[i]) begin
      write_key_len(codes[i]);
      for (int j = 0; j < 12; j++) send_byte(8'($urandom), 1'b0);
      wait_idle();
    end
  endtask

  // Dumps of back-to-back expansions, broken ones and noise
  task automatic test_random();
    int nk;
    int pick;
    int stop_at;
    stop_at = n_bytes + 340;
    while (n_bytes < stop_at) begin
      write_key_len(4'($urandom_range(0, 15)));
      nk = eff_nk(key_len_reg);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      send_byte(8'($urandom), 1'b1);
      for (int k = 0; k < 3 && n_bytes < stop_at; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) send_schedule(nk, 1'b0, 1'b0);
        else if (pick < 8) send_schedule(nk, 1'b0, 1'b1);
        else send_noise($urandom_range(1, 40));
      end
      wait_idle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Long receiver hold while bytes keep coming over a full window: input must back up
  task automatic test_backpressure();
    write_key_len(4'd4);
    tx_idle = 1'b0;
    rx_hold = 1'b1;
    for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'b0);
    tx_idle = 1'b1;
    wait_idle();
  endtask

  // Receiver: random stalls per word, plus the long hold on request
  initial begin : rx_proc
    int n;
    forever begin
      n = rx_idle ? $urandom_range(0, 17) : 0;
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end else if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected word offset=%0d found=%0b",
                         out_word.offset, out_word.found));
      end else begin
        exp_w = pending_q.pop_front();
        n_results++;
        if (exp_w.found) n_found++;
        if (out_word.offset !== exp_w.offset)
          report($sformatf("offset %0d, want %0d", out_word.offset, exp_w.offset));
        if (out_word.found !== exp_w.found)
          report($sformatf("found %0b at offset %0d, want %0b",
                           out_word.found, exp_w.offset, exp_w.found));
      end
    end
  end

  initial begin : timeout
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : main
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    wait_idle();
    $display("Sent %0d bytes over all key lengths; checked %0d words, %0d with a key found.",
             n_bytes, n_results, n_found);
    $display("Mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
